/* rtl/core/bse_pkg.sv */
// Shared types and operation codes of the bitmap search engine.
package bse_pkg;

  localparam int unsigned CntW = 11;

  localparam logic [3:0] MODE_CLEAR  = 4'd0;
  localparam logic [3:0] MODE_INVERT = 4'd1;
  localparam logic [3:0] MODE_SETN   = 4'd2;
  localparam logic [3:0] MODE_FIND   = 4'd3;
  localparam logic [3:0] MODE_POP    = 4'd4;
  localparam logic [3:0] MODE_EMPTY  = 4'd5;
  localparam logic [3:0] MODE_LOAD   = 4'd6;
  localparam logic [3:0] MODE_OR     = 4'd7;
  localparam logic [3:0] MODE_AND    = 4'd8;

  localparam logic [CntW-1:0] SIZE_RST = 11'd1024;

  localparam logic REG_SIZE_BITS = 1'b0;

  typedef struct packed {
    logic [3:0]      mode;
    logic [CntW-1:0] bit_arg;
    logic [3:0]      word_index;
    logic [63:0]     word_value;
    logic            last_word;
  } bse_in_t;

  typedef struct packed {
    logic [CntW-1:0] result_count;
    logic            empty_flag;
  } bse_out_t;

  // Per-word status from the word unit to the sequencer.
  typedef struct packed {
    logic            found;
    logic [CntW-1:0] found_cnt;
    logic [6:0]      ones;
  } bse_stat_t;

endpackage

/* rtl/core/bitmap_search_engine_core.sv */
// Bitmap search engine: sequencer, configuration register and word storage.
//
// Usage: one operation word enters on the input channel (in_valid_i / in_stall_o)
// and exactly one result word leaves on the output channel (out_valid_o /
// out_stall_i). The bitmap is held in a RAM of WORDS words; every operation
// sweeps all words through one shared word unit, one word per cycle, reading
// word i while writing back word i-1. The input stalls until an item's result
// has moved into the output register, so a new item is not accepted while the
// previous one is still being swept or is waiting for the output register.
// The size_bits register sits on the APB port at byte address 0; it should be
// written only while no operation is in flight.
// Reset clears the sequencer, the output valid bit and one valid bit per word,
// so every word reads as zero until its first write-back; size_bits returns to
// 1024. A result held by out_stall_i stays in the output register; a further
// item may be accepted and swept meanwhile, and its result waits in the
// sequencer until the output register is free.
module bitmap_search_engine_core #(
  parameter int unsigned WORDS     = 16,
  parameter int unsigned WORD_BITS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bse_pkg::bse_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bse_pkg::bse_out_t out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import bse_pkg::*;

  localparam int unsigned IW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned CW = (($clog2(WORDS*WORD_BITS) > 11) ?
                                $clog2(WORDS*WORD_BITS) : 11) + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]           state_q, state_d;
  bse_in_t              op_q;
  logic [10:0]          size_q;
  logic [IW-1:0]        rd_idx_q;
  logic                 iss_done_q;
  logic                 p_vld_q;
  logic [IW-1:0]        p_idx_q;
  logic                 ent_vld_q;
  logic [CW-1:0]        base_q;
  logic [CntW-1:0]      cnt_q;
  logic                 found_q;
  logic [CntW-1:0]      fcnt_q;
  logic                 nz_q;
  logic [WORDS-1:0]     vld_q;
  logic                 out_valid_q;
  bse_out_t             out_data_q;

  logic                 accept;
  logic                 issue;
  logic                 fin_go;
  logic                 last_proc;
  logic                 cfg_we;
  logic [WORD_BITS-1:0] rdata;
  logic [WORD_BITS-1:0] word_in;
  logic [WORD_BITS-1:0] word_new;
  bse_stat_t            stat;
  logic [CntW-1:0]      result;

  assign accept    = (state_q == S_IDLE) && in_valid_i;
  assign issue     = (state_q == S_RUN) && !iss_done_q;
  assign last_proc = p_vld_q && (p_idx_q == IW'(WORDS - 1));
  assign fin_go    = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = S_RUN;
      S_RUN:  if (last_proc) state_d = S_FIN;
      S_FIN:  if (fin_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Configuration port.
  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SIZE_BITS) ? 32'(size_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RST;
    end else if (cfg_we && (paddr[2] == REG_SIZE_BITS)) begin
      size_q <= pwdata[10:0];
    end
  end

  bse_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(WORDS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (p_vld_q),
    .waddr_i(p_idx_q),
    .wdata_i(word_new),
    .re_i   (issue),
    .raddr_i(rd_idx_q),
    .rdata_o(rdata)
  );

  // A word never written since reset reads as zero.
  assign word_in = rdata & {WORD_BITS{ent_vld_q}};

  bse_word_unit #(
    .WORDS    (WORDS),
    .WORD_BITS(WORD_BITS)
  ) u_word (
    .op_i  (op_q),
    .size_i(size_q),
    .idx_i (p_idx_q),
    .base_i(base_q),
    .word_i(word_in),
    .word_o(word_new),
    .stat_o(stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      rd_idx_q   <= '0;
      iss_done_q <= 1'b0;
      p_vld_q    <= 1'b0;
      vld_q      <= '0;
    end else begin
      state_q <= state_d;
      p_vld_q <= issue;
      if (accept) begin
        rd_idx_q   <= '0;
        iss_done_q <= 1'b0;
      end else if (issue) begin
        if (rd_idx_q == IW'(WORDS - 1)) iss_done_q <= 1'b1;
        else rd_idx_q <= rd_idx_q + IW'(1);
      end
      if (p_vld_q) vld_q[p_idx_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= in_data_i;
      base_q  <= '0;
      cnt_q   <= '0;
      found_q <= 1'b0;
      fcnt_q  <= '0;
      nz_q    <= 1'b0;
    end else if (p_vld_q) begin
      base_q <= base_q + CW'(WORD_BITS);
      cnt_q  <= cnt_q + CntW'(stat.ones);
      nz_q   <= nz_q | (|word_new);
      if (!found_q && stat.found) begin
        found_q <= 1'b1;
        fcnt_q  <= stat.found_cnt;
      end
    end
    if (issue) begin
      p_idx_q   <= rd_idx_q;
      ent_vld_q <= vld_q[rd_idx_q];
    end
  end

  always_comb begin
    case (op_q.mode)
      MODE_FIND: result = found_q ? fcnt_q : '0;
      MODE_POP:  result = cnt_q;
      default:   result = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_go) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      out_data_q.result_count <= result;
      out_data_q.empty_flag   <= !nz_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The write-back stage only runs inside a sweep.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_vld_q |-> (state_q == S_RUN))
    else $error("word write-back outside a sweep");

  // A new sweep starts with an empty write-back stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_RUN) && !p_vld_q)
    else $error("sweep did not start cleanly");

  // A result only appears after the sweep has finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_FIN))
    else $error("result raised outside the finish state");

  // A finished result waits while the output register is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_FIN) && out_valid_q && out_stall_i) |=> (state_q == S_FIN))
    else $error("result overwrote a stalled output");

endmodule

/* rtl/core/bse_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bse_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/bse_word_unit.sv */
// Shared per-word unit: computes the new value of one storage word and its search/count status.
module bse_word_unit #(
  parameter int unsigned WORDS     = 16,
  parameter int unsigned WORD_BITS = 64
) (
  input  bse_pkg::bse_in_t                                  op_i,
  input  logic [10:0]                                       size_i,
  input  logic [(WORDS > 1 ? $clog2(WORDS) : 1)-1:0]        idx_i,
  input  logic [(($clog2(WORDS*WORD_BITS) > 11) ?
                 $clog2(WORDS*WORD_BITS) : 11):0]           base_i,
  input  logic [WORD_BITS-1:0]                              word_i,
  output logic [WORD_BITS-1:0]                              word_o,
  output bse_pkg::bse_stat_t                                stat_o
);
  import bse_pkg::*;

  localparam int unsigned IW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned CW = (($clog2(WORDS*WORD_BITS) > 11) ?
                                $clog2(WORDS*WORD_BITS) : 11) + 1;
  localparam int unsigned LW = $clog2(WORD_BITS);
  localparam int unsigned XW = (IW > 4) ? IW : 4;

  // Mask of the bits of this word that lie below lim.
  function automatic logic [WORD_BITS-1:0] lmask(input logic [CW-1:0] lim,
                                                  input logic [CW-1:0] base);
    logic [CW-1:0] diff;
    diff = lim - base;
    if (lim <= base) return '0;
    else if (diff >= CW'(WORD_BITS)) return '1;
    else return ~({WORD_BITS{1'b1}} << diff[LW-1:0]);
  endfunction

  logic [WORD_BITS-1:0] wval;
  logic [WORD_BITS-1:0] cand;
  logic [LW-1:0]        pos;
  logic [XW-1:0]        idx_x;
  logic [XW-1:0]        tgt_x;
  logic                 is_tgt;
  logic                 above_tgt;
  logic [CW-1:0]        hit_sum;

  assign wval      = op_i.word_value[WORD_BITS-1:0];
  assign idx_x     = XW'(idx_i);
  assign tgt_x     = XW'(op_i.word_index);
  assign is_tgt    = (idx_x == tgt_x);
  assign above_tgt = (idx_x > tgt_x);

  always_comb begin
    case (op_i.mode)
      MODE_CLEAR:  word_o = '0;
      MODE_INVERT: word_o = ~word_i & lmask(CW'(size_i), base_i);
      MODE_SETN:   word_o = lmask(CW'(op_i.bit_arg), base_i);
      MODE_LOAD:   word_o = is_tgt ? wval : word_i;
      MODE_OR:     word_o = is_tgt ? (word_i | wval) : word_i;
      MODE_AND: begin
        if (is_tgt) word_o = word_i & wval;
        else if (above_tgt && op_i.last_word) word_o = '0;
        else word_o = word_i;
      end
      default:     word_o = word_i;
    endcase
  end

  // Bits below the start index are out of the search.
  assign cand = word_i & ~lmask(CW'(op_i.bit_arg), base_i);

  always_comb begin
    pos = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (cand[b]) pos = LW'(b);
    end
  end

  assign hit_sum = base_i + CW'(pos) + CW'(1);

  assign stat_o.found     = (op_i.mode == MODE_FIND) && (|cand);
  assign stat_o.found_cnt = hit_sum[CntW-1:0];
  assign stat_o.ones      = 7'($countones(word_i));

endmodule

/* test/tb_bitmap_search_engine_core.sv */
// Self-checking testbench for the bitmap search engine core.
`timescale 1ns / 1ps

module tb_bitmap_search_engine_core;
  import bse_pkg::*;

  localparam int unsigned NumWords = 16;
  localparam int unsigned WordBits = 64;
  localparam int unsigned Capacity = NumWords * WordBits;
  localparam int unsigned PhaseItems = 255;
  localparam int unsigned LongHold = 300;
  localparam int unsigned DrainCycles = 40;
  localparam logic [3:0] MODE_SPARE_LO = 4'd9;
  localparam logic [3:0] MODE_SPARE_HI = 4'd15;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  bse_in_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  bse_out_t out_data_o;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  bitmap_search_engine_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Shadow copy of the bitmap and the size register.
  logic [WordBits-1:0] shadow_words [NumWords];
  logic [CntW-1:0] shadow_size;
  bse_out_t pending_results [$];
  int unsigned mismatches;
  bit hold_req;
  bit calm;

  typedef struct {
    logic [3:0]  mode;
    int unsigned bit_arg;
    int unsigned idx;
    logic [63:0] value;
    bit          last;
    bit          typed;
    int unsigned want_count;
    bit          want_empty;
  } op_row_t;

  // Directed rows run at the reset size of 1024 bits.
  op_row_t directed_ops [26] = '{
    '{MODE_POP,       0,    0,  64'h0, 0, 1, 0,    1},
    '{MODE_FIND,      0,    0,  64'h0, 0, 1, 0,    1},
    '{MODE_EMPTY,     0,    0,  64'h0, 0, 1, 0,    1},
    '{MODE_SETN,      1024, 0,  64'h0, 0, 1, 0,    0},
    '{MODE_POP,       0,    0,  64'h0, 0, 1, 1024, 0},
    '{MODE_FIND,      0,    0,  64'h0, 0, 1, 1,    0},
    '{MODE_FIND,      1023, 0,  64'h0, 0, 1, 1024, 0},
    '{MODE_FIND,      1024, 0,  64'h0, 0, 1, 0,    0},
    '{MODE_FIND,      2047, 0,  64'h0, 0, 1, 0,    0},
    '{MODE_INVERT,    0,    0,  64'h0, 0, 1, 0,    1},
    '{MODE_SETN,      2047, 0,  64'h0, 0, 1, 0,    0},
    '{MODE_POP,       0,    0,  64'h0, 0, 1, 1024, 0},
    '{MODE_CLEAR,     0,    0,  64'h0, 0, 1, 0,    1},
    '{MODE_SETN,      0,    0,  64'h0, 0, 1, 0,    1},
    '{MODE_LOAD,      0,    15, ALL_ONES, 0, 0, 0, 0},
    '{MODE_FIND,      0,    0,  64'h0, 0, 1, 961,  0},
    '{MODE_AND,       0,    3,  64'h0, 1, 1, 0,    1},
    '{MODE_LOAD,      0,    0,  64'h8000_0000_0000_0000, 1, 0, 0, 0},
    '{MODE_OR,        0,    0,  64'h1, 1, 0, 0,    0},
    '{MODE_POP,       0,    0,  64'h0, 0, 1, 2,    0},
    '{MODE_SPARE_LO,  5,    0,  64'h0, 0, 1, 0,    0},
    '{MODE_SPARE_HI,  2047, 15, ALL_ONES, 1, 1, 0, 0},
    '{MODE_AND,       0,    0,  ALL_ONES, 1, 0, 0, 0},
    '{MODE_INVERT,    0,    0,  64'h0, 0, 0, 0,    0},
    '{MODE_FIND,      64,   0,  64'h0, 0, 0, 0,    0},
    '{MODE_SETN,      65,   0,  64'h0, 0, 0, 0,    0}
  };

  task automatic note_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    mismatches++;
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
  endtask

  // Applies one operation to the shadow bitmap and returns the word it yields.
  function automatic bse_out_t bitmap_apply(input bse_in_t op);
    bse_out_t r;
    int unsigned lim;
    int unsigned n;
    bit any;
    r = '0;
    case (op.mode)
      MODE_CLEAR: begin
        for (int w = 0; w < NumWords; w++) shadow_words[w] = '0;
      end
      MODE_INVERT: begin
        lim = (shadow_size > Capacity) ? Capacity : shadow_size;
        for (int w = 0; w < NumWords; w++) shadow_words[w] = ~shadow_words[w];
        for (int b = lim; b < Capacity; b++) shadow_words[b / WordBits][b % WordBits] = 1'b0;
      end
      MODE_SETN: begin
        for (int b = 0; b < Capacity; b++) begin
          shadow_words[b / WordBits][b % WordBits] = (b < op.bit_arg);
        end
      end
      MODE_FIND: begin
        for (int b = op.bit_arg; b < Capacity; b++) begin
          if (shadow_words[b / WordBits][b % WordBits]) begin
            r.result_count = CntW'(b + 1);
            break;
          end
        end
      end
      MODE_POP: begin
        n = 0;
        for (int w = 0; w < NumWords; w++) n += $countones(shadow_words[w]);
        r.result_count = CntW'(n);
      end
      MODE_LOAD: shadow_words[op.word_index] = op.word_value;
      MODE_OR:   shadow_words[op.word_index] |= op.word_value;
      MODE_AND: begin
        shadow_words[op.word_index] &= op.word_value;
        if (op.last_word) begin
          for (int w = op.word_index + 1; w < NumWords; w++) shadow_words[w] = '0;
        end
      end
      default: ;
    endcase
    any = 1'b0;
    for (int w = 0; w < NumWords; w++) any |= |shadow_words[w];
    r.empty_flag = !any;
    return r;
  endfunction

  function automatic bse_in_t random_op();
    bse_in_t d;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) d.mode = MODE_CLEAR;
    else if (pick < 9) d.mode = MODE_INVERT;
    else if (pick < 15) d.mode = MODE_SETN;
    else if (pick < 40) d.mode = MODE_FIND;
    else if (pick < 49) d.mode = MODE_POP;
    else if (pick < 54) d.mode = MODE_EMPTY;
    else if (pick < 70) d.mode = MODE_LOAD;
    else if (pick < 82) d.mode = MODE_OR;
    else if (pick < 95) d.mode = MODE_AND;
    else d.mode = 4'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
    case ($urandom_range(0, 5))
      0: d.bit_arg = CntW'($urandom_range(0, 2047));
      1: d.bit_arg = CntW'(WordBits * $urandom_range(0, NumWords));
      2: d.bit_arg = CntW'(WordBits * $urandom_range(1, NumWords) - 1);
      default: d.bit_arg = CntW'($urandom_range(0, Capacity - 1));
    endcase
    d.word_index = 4'($urandom_range(0, NumWords - 1));
    case ($urandom_range(0, 5))
      0: d.word_value = ALL_ONES;
      1: d.word_value = '0;
      2: d.word_value = 64'd1 << $urandom_range(0, 63);
      3: d.word_value = ~(64'd1 << $urandom_range(0, 63));
      default: d.word_value = {$urandom, $urandom};
    endcase
    d.last_word = 1'($urandom_range(0, 1));
    return d;
  endfunction

  // Offers one word and returns once it has been taken.
  task automatic offer_op(input bse_in_t op, input bit typed, input bse_out_t want);
    bse_out_t predicted;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i = op;
    do @(posedge clk_i); while (in_stall_o);
    predicted = bitmap_apply(op);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk_i);
    end
  endtask

  task automatic go_quiet_and_drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_access(input bit wr, input logic [CntW-1:0] value);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = {REG_SIZE_BITS, 2'b00};
    pwdata = 32'(value);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (wr) begin
      shadow_size = value;
    end else if (prdata !== 32'(shadow_size)) begin
      note_mismatch("size_bits readback", 64'(prdata), 64'(shadow_size));
    end
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #8ms;
    $display("tb_bitmap_search_engine_core failed");
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin : receiver
    int unsigned stall_hold_cycles;
    bit held;
    held = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !held) begin
        out_stall_i = 1'b1;
        stall_hold_cycles = 0;
        while (stall_hold_cycles < LongHold) begin
          @(negedge clk_i);
          stall_hold_cycles++;
        end
        held = 1'b1;
        out_stall_i = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
        out_stall_i = 1'b0;
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    bse_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        note_mismatch("result word with nothing pending", 64'(out_data_o), 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.result_count !== want.result_count) begin
          note_mismatch("result_count", 64'(out_data_o.result_count),
                        64'(want.result_count));
        end
        if (out_data_o.empty_flag !== want.empty_flag) begin
          note_mismatch("empty_flag", 64'(out_data_o.empty_flag), 64'(want.empty_flag));
        end
      end
    end
  end

  initial begin : stimulus
    logic [CntW-1:0] size_plan [7];
    bse_in_t op;
    bse_out_t want;
    mismatches = 0;
    hold_req = 1'b0;
    calm = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    for (int w = 0; w < NumWords; w++) shadow_words[w] = '0;
    shadow_size = SIZE_RST;
    size_plan = '{11'd0, 11'd2047, 11'd1, 11'd64, CntW'($urandom_range(0, 2047)),
                  11'd1023, 11'd1024};
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    apb_access(1'b0, '0);
    foreach (directed_ops[i]) begin
      op.mode = directed_ops[i].mode;
      op.bit_arg = CntW'(directed_ops[i].bit_arg);
      op.word_index = 4'(directed_ops[i].idx);
      op.word_value = directed_ops[i].value;
      op.last_word = directed_ops[i].last;
      want.result_count = CntW'(directed_ops[i].want_count);
      want.empty_flag = directed_ops[i].want_empty;
      offer_op(op, directed_ops[i].typed, want);
    end
    go_quiet_and_drain();

    foreach (size_plan[p]) begin
      apb_access(1'b1, size_plan[p]);
      apb_access(1'b0, '0);
      // Keep the receiver blocked for a while so the input side backs up.
      if (p == 2) hold_req = 1'b1;
      if (p == 6) calm = 1'b1;
      for (int n = 0; n < PhaseItems; n++) begin
        sender_gap();
        offer_op(random_op(), 1'b0, '0);
      end
      go_quiet_and_drain();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_bitmap_search_engine_core passed");
    end else begin
      $display("tb_bitmap_search_engine_core failed");
    end
    $finish;
  end

endmodule
